// ===== rtl/tdmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdmf_pkg
// Shared types, font and map tables of the two-digit matrix font renderer.
// ----------------------------------------------------------------------------
package tdmf_pkg;

  localparam int FontHeight  = 9;
  localparam int FontWidth   = 3;
  localparam int MaxLevel    = 10;
  localparam int SatValue    = 99;
  localparam int QueueDepth  = 2;

  localparam int RowW = $clog2(FontHeight);
  localparam int ColW = $clog2(FontWidth);

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  typedef logic [FontHeight-1:0] glyph_col_t;

  localparam logic [7:0] GammaTab [MaxLevel+1] = '{
    8'd0, 8'd4, 8'd8, 8'd16, 8'd28, 8'd45, 8'd68, 8'd95, 8'd128, 8'd180, 8'd255
  };

  localparam glyph_col_t GlyphTab [10][FontWidth] = '{
    '{9'h1FF, 9'h101, 9'h1FF},
    '{9'h000, 9'h1FF, 9'h000},
    '{9'h1F1, 9'h111, 9'h11F},
    '{9'h111, 9'h111, 9'h1FF},
    '{9'h01F, 9'h010, 9'h1FF},
    '{9'h11F, 9'h111, 9'h1F1},
    '{9'h1FF, 9'h111, 9'h1F1},
    '{9'h001, 9'h001, 9'h1FF},
    '{9'h1FF, 9'h111, 9'h1FF},
    '{9'h11F, 9'h111, 9'h1FF}
  };

  // column of a digit, after the gap column: units start at logical column 5
  function automatic logic [3:0] col_to_com(input logic digit_sel, input logic [ColW-1:0] x);
    logic [3:0] base;
    base = digit_sel ? 4'd5 : 4'd1;
    return base + 4'(x);
  endfunction

  function automatic logic [3:0] row_to_seg(input logic [RowW-1:0] y);
    return 4'(5'd11 - 5'(y));
  endfunction

  function automatic glyph_col_t glyph_col(input logic [3:0] digit, input logic [ColW-1:0] x);
    glyph_col_t col;
    col = '0;
    if (digit < 4'd10) begin
      col = GlyphTab[digit][x];
    end
    return col;
  endfunction

  function automatic logic [7:0] gamma_level(input logic [7:0] level);
    logic [7:0] pwm;
    pwm = 8'd255;
    if (level <= 8'(MaxLevel)) begin
      pwm = GammaTab[level[3:0]];
    end
    return pwm;
  endfunction

endpackage

// ===== rtl/two_digit_matrix_font_renderer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_digit_matrix_font_renderer_unit
// Turns a number into the LED matrix pixel writes of two 3x9 font digits.
// ----------------------------------------------------------------------------
// usage
//   input channel: one number request per handshake (in_valid_i/in_ready_o),
//   saturated at 99 and split into tens and units in the front stage
//   output channel: 54 pixel write requests per number, tens digit first,
//   then column, then row; last_write_o marks the final one
//   config channel: cfg_data_i sets the brightness level, write when idle
//   first write: the number passes the queue and the sequencer state
//   to the output register; throughput: the pixel sequencer makes one
//   write per cycle unless stalled; a short queue holds numbers taken meanwhile
//   receiver stall: the output register holds its request and the
//   sequencer pauses; input ready drops once the queue is full
//   reset: queue and sequencer empty, brightness level 0
// ----------------------------------------------------------------------------
module two_digit_matrix_font_renderer_unit #(
  parameter int QUEUE_DEPTH = tdmf_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] number_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  com_index_o,
  output logic [3:0]  seg_index_o,
  output logic [7:0]  pixel_level_o,
  output logic        last_write_o
);
  import tdmf_pkg::*;

  logic [7:0] brightness_q;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  digits_t    push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      brightness_q <= cfg_data_i;
    end
  end

  tdmf_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .number_value_i (number_value_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  tdmf_queue #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(digits_t))
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  tdmf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .brightness_i  (brightness_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .com_index_o   (com_index_o),
    .seg_index_o   (seg_index_o),
    .pixel_level_o (pixel_level_o),
    .last_write_o  (last_write_o)
  );

  a_last_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_write_o |-> com_index_o == 4'd7 && seg_index_o == 4'd3)
    else $error("last write not at final pixel");

  a_com_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> com_index_o != 4'd0 && com_index_o != 4'd4 && com_index_o < 4'd8)
    else $error("com index outside digit columns");

  a_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_level_o != 8'd0 |-> pixel_level_o == gamma_level(brightness_q))
    else $error("pixel level differs from brightness");

  a_seg_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seg_index_o >= 4'd3 && seg_index_o <= 4'd11)
    else $error("seg index outside font rows");

endmodule

// ===== rtl/tdmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdmf_front
// Takes number requests, saturates at 99 and splits into tens and units.
// ----------------------------------------------------------------------------
module tdmf_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       number_value_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output tdmf_pkg::digits_t push_data_o
);
  import tdmf_pkg::*;

  logic [6:0]  sat_value;
  logic [14:0] recip_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;

  always_comb begin
    sat_value = (number_value_i > 16'(SatValue)) ? 7'(SatValue) : number_value_i[6:0];
    // divide by ten via reciprocal, exact below 100
    recip_prod = 15'(sat_value) * 15'd205;
    tens       = recip_prod[14:11];
    tens_x10   = 7'(tens) * 7'd10;
  end

  assign push_data_o.tens  = tens;
  assign push_data_o.units = 4'(sat_value - tens_x10);
  assign push_valid_o      = in_valid_i;
  assign in_ready_o        = push_ready_i;

endmodule

// ===== rtl/tdmf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdmf_queue
// Small register queue between the front and the pixel sequencer.
// ----------------------------------------------------------------------------
module tdmf_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = count_q != CntW'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/tdmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdmf_back
// Pixel sequencer: walks digit, column and row, one pixel write per cycle unless stalled.
// ----------------------------------------------------------------------------
module tdmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  tdmf_pkg::digits_t pop_data_i,
  input  logic [7:0]        brightness_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        com_index_o,
  output logic [3:0]        seg_index_o,
  output logic [7:0]        pixel_level_o,
  output logic              last_write_o
);
  import tdmf_pkg::*;

  logic            active_q, active_d;
  digits_t         digits_q;
  logic            dsel_q, dsel_d;
  logic [ColW-1:0] x_q, x_d;
  logic [RowW-1:0] y_q, y_d;
  logic            ovalid_q, ovalid_d;
  logic [3:0]      com_q, seg_q;
  logic [7:0]      level_q;
  logic            last_q;

  logic            can_emit, emit, x_last, y_last, item_done, load;
  logic [3:0]      cur_digit;
  glyph_col_t      cur_col;

  assign can_emit  = !ovalid_q || out_ready_i;
  assign emit      = active_q && can_emit;
  assign y_last    = y_q == RowW'(FontHeight - 1);
  assign x_last    = x_q == ColW'(FontWidth - 1);
  assign item_done = dsel_q && x_last && y_last;
  assign load      = pop_valid_i && (!active_q || (emit && item_done));
  assign pop_ready_o = !active_q || (emit && item_done);
  assign cur_digit = dsel_q ? digits_q.units : digits_q.tens;
  assign cur_col   = glyph_col(cur_digit, x_q);

  always_comb begin
    active_d = active_q;
    dsel_d   = dsel_q;
    x_d      = x_q;
    y_d      = y_q;
    ovalid_d = ovalid_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (emit) begin
      ovalid_d = 1'b1;
      if (y_last) begin
        y_d = '0;
        if (x_last) begin
          x_d    = '0;
          dsel_d = !dsel_q;
        end else begin
          x_d = x_q + 1'b1;
        end
      end else begin
        y_d = y_q + 1'b1;
      end
      if (item_done) begin
        active_d = 1'b0;
      end
    end
    if (load) begin
      active_d = 1'b1;
      dsel_d   = 1'b0;
      x_d      = '0;
      y_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      dsel_q   <= 1'b0;
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      dsel_q   <= dsel_d;
      x_q      <= x_d;
      y_q      <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= pop_data_i;
    end
    if (emit) begin
      com_q   <= col_to_com(dsel_q, x_q);
      seg_q   <= row_to_seg(y_q);
      level_q <= cur_col[y_q] ? gamma_level(brightness_i) : 8'd0;
      last_q  <= item_done;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign com_index_o   = com_q;
  assign seg_index_o   = seg_q;
  assign pixel_level_o = level_q;
  assign last_write_o  = last_q;

endmodule
